>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk_i with reset rst_ni
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge once reset is released
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// property checked at every clock edge, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/ccsp_pkg.sv
// ----------------------------------------------------------------------------
// ccsp_pkg
// types, constants and the byte classifier of the stable partition unit
// ----------------------------------------------------------------------------
`default_nettype none

package ccsp_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;

  typedef enum logic [1:0] {
    CLS_LETTER = 2'd0,
    CLS_DIGIT  = 2'd1,
    CLS_OTHER  = 2'd2
  } class_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_SHOW
  } state_e;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_string;
  } in_beat_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic [1:0] char_class;
    logic       last_out;
    logic       overflow;
  } out_beat_t;

  // controller to datapath
  typedef struct packed {
    logic store;   // input beat taken, store or drop it
    logic start;   // load first read position
    logic step;    // result taken, load next read position
    logic clear;   // last result taken, clear counts and flag
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last;    // current read position is the final one
  } status_t;

  function automatic class_e classify(input logic [7:0] b);
    class_e c;
    if ((b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) ||
        (b >= CHAR_LOWER_A && b <= CHAR_LOWER_Z)) begin
      c = CLS_LETTER;
    end else if (b >= CHAR_ZERO && b <= CHAR_NINE) begin
      c = CLS_DIGIT;
    end else begin
      c = CLS_OTHER;
    end
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/char_class_stable_partition_unit.sv
// ----------------------------------------------------------------------------
// char_class_stable_partition_unit: stable letter / digit / other partition
// input: one beat per cycle while collecting; the stores' write ports set this
// output: results follow the seek state, then one per cycle unless stalled
// reset: async, clears counts and overflow flag; stores keep stale contents
// ----------------------------------------------------------------------------
`default_nettype none

module char_class_stable_partition_unit #(
  parameter int MAX_LEN = 64   // bytes one string may hold, 1..64
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // input channel
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire ccsp_pkg::in_beat_t  in_beat_i,
  // result channel
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output ccsp_pkg::out_beat_t      out_beat_o
);

  import ccsp_pkg::*;

  // a string is collected into the class stores, then a seek state loads the
  // first read position and the results follow; the input is stalled from the
  // final beat until the last result beat is taken

  cmd_t    cmd;
  status_t status;

  // sequencer: idle (collect), seek (first read), show (one result a beat)
  ccsp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_eos_i    (in_beat_i.end_of_string),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .status_i    (status)
  );

  // three class stores with their counts, and the read walker; the
  // registered ram read data is the output register and holds under stall
  ccsp_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_beat_i  (in_beat_i),
    .status_o   (status),
    .out_beat_o (out_beat_o)
  );

endmodule

`default_nettype wire

>>> rtl/ccsp_ram.sv
// ----------------------------------------------------------------------------
// ccsp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module ccsp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> rtl/ccsp_ctrl.sv
// ----------------------------------------------------------------------------
// ccsp_ctrl
// sequencer: collect beats, then walk the three class stores
// ----------------------------------------------------------------------------
`default_nettype none

module ccsp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_eos_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output ccsp_pkg::cmd_t         cmd_o,
  input  wire ccsp_pkg::status_t status_i
);

  import ccsp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_eos_i) begin
          state_d = ST_SEEK;
        end
      end
      ST_SEEK: begin
        state_d = ST_SHOW;
      end
      ST_SHOW: begin
        if (!out_stall_i && status_i.last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    cmd_o       = '0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o  = 1'b0;
        cmd_o.store = in_valid_i;
      end
      ST_SEEK: begin
        cmd_o.start = 1'b1;
      end
      ST_SHOW: begin
        out_valid_o = 1'b1;
        cmd_o.step  = !out_stall_i && !status_i.last;
        cmd_o.clear = !out_stall_i && status_i.last;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/ccsp_datapath.sv
// ----------------------------------------------------------------------------
// ccsp_datapath
// class stores, fill counts, overflow flag and read position walker
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module ccsp_datapath #(
  parameter int MAX_LEN = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire ccsp_pkg::cmd_t     cmd_i,
  input  wire ccsp_pkg::in_beat_t in_beat_i,
  output ccsp_pkg::status_t       status_o,
  output ccsp_pkg::out_beat_t     out_beat_o
);

  import ccsp_pkg::*;

  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int PW = AW + 1;
  localparam int UW = CW + 2;

  logic [CW-1:0] ltot_q, ltot_d, dtot_q, dtot_d, otot_q, otot_d;
  logic          drop_q, drop_d;
  class_e        pos_cls_q, pos_cls_d;
  logic [AW-1:0] pos_idx_q, pos_idx_d;

  class_e        in_cls;
  logic [UW-1:0] used;
  logic          full;
  logic          wr_ok;
  logic          we_l, we_d, we_o;
  logic [CW-1:0] cur_tot;
  logic [PW-1:0] idx_inc;
  logic          more_same;
  logic          has_next;
  class_e        nx_cls;
  logic [AW-1:0] nx_idx;
  class_e        fst_cls;
  logic          load;
  logic [7:0]    rd_l, rd_d, rd_o;
  logic [7:0]    rd_sel;

  // fill side
  assign in_cls = classify(in_beat_i.char_in);
  assign used   = UW'(ltot_q) + UW'(dtot_q) + UW'(otot_q);
  assign full   = used >= UW'(MAX_LEN);
  assign wr_ok  = cmd_i.store && !full;
  assign we_l   = wr_ok && (in_cls == CLS_LETTER);
  assign we_d   = wr_ok && (in_cls == CLS_DIGIT);
  assign we_o   = wr_ok && (in_cls == CLS_OTHER);

  always_comb begin
    ltot_d = ltot_q;
    dtot_d = dtot_q;
    otot_d = otot_q;
    drop_d = drop_q;
    if (cmd_i.clear) begin
      ltot_d = '0;
      dtot_d = '0;
      otot_d = '0;
      drop_d = 1'b0;
    end else begin
      if (we_l) ltot_d = ltot_q + CW'(1);
      if (we_d) dtot_d = dtot_q + CW'(1);
      if (we_o) otot_d = otot_q + CW'(1);
      if (cmd_i.store && full) drop_d = 1'b1;
    end
  end

  // read walker: letters, then digits, then others
  always_comb begin
    case (pos_cls_q)
      CLS_LETTER: cur_tot = ltot_q;
      CLS_DIGIT:  cur_tot = dtot_q;
      CLS_OTHER:  cur_tot = otot_q;
      default:    cur_tot = '0;
    endcase
  end

  assign idx_inc   = PW'(pos_idx_q) + PW'(1);
  assign more_same = idx_inc < PW'(cur_tot);

  always_comb begin
    has_next = 1'b1;
    nx_cls   = pos_cls_q;
    nx_idx   = idx_inc[AW-1:0];
    if (!more_same) begin
      nx_idx = '0;
      case (pos_cls_q)
        CLS_LETTER: begin
          if (dtot_q != '0) begin
            nx_cls = CLS_DIGIT;
          end else if (otot_q != '0) begin
            nx_cls = CLS_OTHER;
          end else begin
            has_next = 1'b0;
          end
        end
        CLS_DIGIT: begin
          if (otot_q != '0) begin
            nx_cls = CLS_OTHER;
          end else begin
            has_next = 1'b0;
          end
        end
        default: begin
          has_next = 1'b0;
        end
      endcase
    end
  end

  assign fst_cls = (ltot_q != '0) ? CLS_LETTER :
                   (dtot_q != '0) ? CLS_DIGIT  : CLS_OTHER;

  assign load      = cmd_i.start || cmd_i.step;
  assign pos_cls_d = cmd_i.start ? fst_cls : nx_cls;
  assign pos_idx_d = cmd_i.start ? '0 : nx_idx;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ltot_q    <= '0;
      dtot_q    <= '0;
      otot_q    <= '0;
      drop_q    <= 1'b0;
      pos_cls_q <= CLS_LETTER;
      pos_idx_q <= '0;
    end else begin
      ltot_q <= ltot_d;
      dtot_q <= dtot_d;
      otot_q <= otot_d;
      drop_q <= drop_d;
      if (load) begin
        pos_cls_q <= pos_cls_d;
        pos_idx_q <= pos_idx_d;
      end
    end
  end

  ccsp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_letter_ram (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (ltot_q[AW-1:0]),
    .wdata_i (in_beat_i.char_in),
    .re_i    (load),
    .raddr_i (pos_idx_d),
    .rdata_o (rd_l)
  );

  ccsp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_digit_ram (
    .clk_i   (clk_i),
    .we_i    (we_d),
    .waddr_i (dtot_q[AW-1:0]),
    .wdata_i (in_beat_i.char_in),
    .re_i    (load),
    .raddr_i (pos_idx_d),
    .rdata_o (rd_d)
  );

  ccsp_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_other_ram (
    .clk_i   (clk_i),
    .we_i    (we_o),
    .waddr_i (otot_q[AW-1:0]),
    .wdata_i (in_beat_i.char_in),
    .re_i    (load),
    .raddr_i (pos_idx_d),
    .rdata_o (rd_o)
  );

  always_comb begin
    case (pos_cls_q)
      CLS_LETTER: rd_sel = rd_l;
      CLS_DIGIT:  rd_sel = rd_d;
      CLS_OTHER:  rd_sel = rd_o;
      default:    rd_sel = '0;
    endcase
  end

  assign out_beat_o.char_out   = rd_sel;
  assign out_beat_o.char_class = pos_cls_q;
  assign out_beat_o.last_out   = !has_next;
  assign out_beat_o.overflow   = drop_q;
  assign status_o.last         = !has_next;

  `ASSERT_RST(a_fill_bound, used <= UW'(MAX_LEN), "fill count exceeds capacity")
  `ASSERT_RST(a_clear_empty, cmd_i.clear |=> (used == '0) && !drop_q, "counts not cleared")
  `ASSERT_RST(a_pos_in_range, load |=> idx_inc <= PW'(cur_tot), "read position past fill count")

endmodule

`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: char_class_stable_partition_unit testbench
// sends byte strings, each closed by an end-of-string beat, with random gaps
// on both channels. a scoreboard predicts the result order (letters, then
// digits, then other bytes, each in arrival order), the last marker and the
// overflow flag, and checks every result beat against it
// ----------------------------------------------------------------------------

module tb;
  import ccsp_pkg::*;

  localparam int CAPACITY     = 64;    // default string capacity of the block
  localparam int ITEM_TARGET  = 460;   // rough number of input beats in the run
  localparam int IDLE_PCT     = 13;    // chance of an idle cycle per side
  localparam int HOLD_CYCLES  = 300;   // long receiver hold-off
  localparam int DRAIN_CYCLES = 20;    // quiet cycles after the last result
  localparam int MAX_PRINTS   = 40;    // mismatch lines shown before going quiet

  // class boundaries and field extremes, first byte in the top bits
  localparam logic [14*8-1:0] BOUNDARY_BYTES =
    {"@AZ[", 8'h60, "az{/09:", 8'h00, 8'hff};
  // interleaved classes, to see that each class keeps its arrival order
  localparam logic [5*8-1:0] MIXED_BYTES = "x7#B3";

  // --------------------------------------------------------------------------
  // scoreboard: per-class byte lists of the open string plus the queue of
  // result beats expected from strings already closed
  // --------------------------------------------------------------------------
  class partition_scoreboard;
    logic [7:0] letters[$];
    logic [7:0] digits[$];
    logic [7:0] others[$];
    bit         dropped = 1'b0;
    out_beat_t  pending[$];
    int         errors = 0;

    task report(string msg);
      if (errors < MAX_PRINTS) $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    // folding bit 5 maps upper case onto lower case, so one range covers both
    function class_e class_of(logic [7:0] b);
      logic [7:0] folded;
      folded = b | 8'h20;
      if (folded >= "a" && folded <= "z") return CLS_LETTER;
      if (b >= "0" && b <= "9") return CLS_DIGIT;
      return CLS_OTHER;
    endfunction

    function void add_result(logic [7:0] b, class_e c, bit last);
      out_beat_t res;
      res.char_out   = b;
      res.char_class = c;
      res.last_out   = last;
      res.overflow   = dropped;
      pending.push_back(res);
    endfunction

    // accepted input beat: store or drop it, and on the final byte queue the
    // whole partitioned string
    function void note_byte(in_beat_t beat);
      int used;
      int k;
      used = letters.size() + digits.size() + others.size();
      if (used >= CAPACITY) begin
        dropped = 1'b1;
      end else begin
        case (class_of(beat.char_in))
          CLS_LETTER: letters.push_back(beat.char_in);
          CLS_DIGIT:  digits.push_back(beat.char_in);
          default:    others.push_back(beat.char_in);
        endcase
      end
      if (beat.end_of_string) begin
        used = letters.size() + digits.size() + others.size();
        k = 0;
        foreach (letters[i]) begin
          add_result(letters[i], CLS_LETTER, k == used - 1);
          k++;
        end
        foreach (digits[i]) begin
          add_result(digits[i], CLS_DIGIT, k == used - 1);
          k++;
        end
        foreach (others[i]) begin
          add_result(others[i], CLS_OTHER, k == used - 1);
          k++;
        end
        letters.delete();
        digits.delete();
        others.delete();
        dropped = 1'b0;
      end
    endfunction

    // accepted result beat: compare with the oldest expected one
    task check_result(out_beat_t got);
      out_beat_t want;
      if (pending.size() == 0) begin
        report($sformatf("result beat %h with nothing expected", got));
        return;
      end
      want = pending.pop_front();
      if (got.char_out !== want.char_out)
        report($sformatf("char_out %h, expected %h", got.char_out, want.char_out));
      if (got.char_class !== want.char_class)
        report($sformatf("char_class %0d, expected %0d (char %h)",
                         got.char_class, want.char_class, want.char_out));
      if (got.last_out !== want.last_out)
        report($sformatf("last_out %b, expected %b (char %h)",
                         got.last_out, want.last_out, want.char_out));
      if (got.overflow !== want.overflow)
        report($sformatf("overflow %b, expected %b (char %h)",
                         got.overflow, want.overflow, want.char_out));
    endtask
  endclass

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_beat_t  in_beat_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_beat_t out_beat_o;

  bit calm     = 1'b0;   // both sides stop idling while set
  bit hold_req = 1'b0;   // asks the receiver for one long hold-off
  int sent     = 0;      // input beats offered by push_byte so far

  partition_scoreboard sb;

  char_class_stable_partition_unit DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_beat_i   (in_beat_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_beat_o  (out_beat_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // generous time-out bound for the whole run
  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // both channels are sampled at the edge, so values are the pre-edge ones
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) sb.note_byte(in_beat_i);
      if (out_valid_o && !out_stall_i) sb.check_result(out_beat_o);
    end
  end

  // receiver: random stalls, none while calm, and one long hold-off on request
  // counted here so the sender keeps offering beats meanwhile
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall_i <= 1'b1;
        hold_left--;
      end else if (calm) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < IDLE_PCT);
      end
    end
  end

  // offer one beat, idling first at random, and return once in_stall_o is seen low after an edge
  task automatic push_byte(input logic [7:0] b, input logic fin);
    in_beat_t beat;
    beat.char_in       = b;
    beat.end_of_string = fin;
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_beat_i  <= beat;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sent++;
  endtask

  // letters and digits are picked on purpose, the rest is any byte at all
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(3))
      0:       pick_byte = 8'(($urandom_range(1) ? "a" : "A") + $urandom_range(25));
      1:       pick_byte = 8'("0" + $urandom_range(9));
      default: pick_byte = 8'($urandom_range(255));
    endcase
  endfunction

  task automatic push_string(input int len);
    for (int i = 0; i < len; i++) push_byte(pick_byte(), i == len - 1);
  endtask

  // sender pause until every expected beat has come; the extra edge lets the
  // monitor note the final byte first
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_beat_i  <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // one-byte strings of each class; the zero byte is plain other
    push_byte("A", 1'b1);
    push_byte("9", 1'b1);
    push_byte(8'h00, 1'b1);
    // bytes on both sides of every class range, zero byte mid-string
    for (int i = 13; i >= 0; i--) push_byte(BOUNDARY_BYTES[i*8 +: 8], i == 0);
    for (int i = 4; i >= 0; i--) push_byte(MIXED_BYTES[i*8 +: 8], i == 0);

    // no idling: a string that fills the stores exactly, then one whose last
    // two bytes, the final one among them, are dropped
    calm = 1'b1;
    push_string(CAPACITY);
    push_string(CAPACITY + 2);
    calm = 1'b0;

    // receiver holds off while strings keep coming, so the input stalls
    hold_req = 1'b1;
    push_string(CAPACITY);
    push_string(5);
    push_string(3);
    wait_drained();

    // mostly short strings, now and then one near or over capacity
    while (sent < ITEM_TARGET) begin
      if ($urandom_range(9) == 0) push_string($urandom_range(CAPACITY + 8, 40));
      else push_string($urandom_range(12, 1));
    end
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ccsp_pkg.sv
rtl/ccsp_ram.sv
rtl/ccsp_ctrl.sv
rtl/ccsp_datapath.sv
rtl/char_class_stable_partition_unit.sv
verif/tb.sv
